// ----- hdl/ast_pkg.sv -----
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types and codes for the address slot table: operation codes,
// transfer payloads, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package ast_pkg;

   localparam int ADDR_W  = 48;
   localparam int SEL_W   = 3;
   localparam int HIT_W   = 3;
   localparam int COUNT_W = 4;
   localparam int COUNT_MAX = 15;

   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_LOOKUP = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   typedef struct packed {
      func_type          func;
      logic [ADDR_W-1:0] address;
      logic [SEL_W-1:0]  slot_select;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic               already_present;
      logic [HIT_W-1:0]   slot_hit;
      logic [ADDR_W-1:0]  slot_data;
      logic [COUNT_W-1:0] occupied_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_MATCH  = 2'd1,
      ST_COMMIT = 2'd2
   } state_type;

   typedef struct packed {
      logic load_req;
      logic capture_match;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_full;
   } status_type;

endpackage

// ----- hdl/ast_ctrl.sv -----
// ----------------------------------------------------------------------------
// ast_ctrl
// Controller for the address slot table: steps each operation through its
// capture, match and commit phases.
// ----------------------------------------------------------------------------
module ast_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ast_pkg::status_type status,
   output ast_pkg::cmd_type    cmd
);

   ast_pkg::state_type state_ff;
   ast_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ast_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ast_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ast_pkg::ST_MATCH;
            end
         end
         ast_pkg::ST_MATCH: begin
            cmd.capture_match = 1'b1;
            state_in          = ast_pkg::ST_COMMIT;
         end
         ast_pkg::ST_COMMIT: begin
            // Hold the finished operation until the result register is free.
            if (!status.out_full) begin
               cmd.commit = 1'b1;
               state_in   = ast_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ast_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/ast_datapath.sv -----
// ----------------------------------------------------------------------------
// ast_datapath
// Slot storage, match vectors, occupancy counter and the result register of
// the address slot table.
// ----------------------------------------------------------------------------
module ast_datapath #(
   parameter int SLOT_COUNT = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  ast_pkg::cmd_type    cmd,
   output ast_pkg::status_type status,
   input  ast_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ast_pkg::rsp_type    rsp_data
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam int EXT_W = (IDX_W > ast_pkg::HIT_W) ? IDX_W : ast_pkg::HIT_W;
   localparam int SAT_W = (CNT_W > ast_pkg::COUNT_W) ? CNT_W : ast_pkg::COUNT_W;

   logic [ast_pkg::ADDR_W-1:0] table_ff [SLOT_COUNT];
   ast_pkg::req_type           req_ff;
   logic [SLOT_COUNT-1:0]      match_ff;
   logic [SLOT_COUNT-1:0]      vacant_ff;
   logic                       addr_nz_ff;
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   ast_pkg::rsp_type           rsp_ff;
   ast_pkg::rsp_type           rsp_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;

   logic                       wr_en;
   logic [IDX_W-1:0]           wr_idx;
   logic [ast_pkg::ADDR_W-1:0] wr_data;
   logic [IDX_W-1:0]           match_idx;
   logic [IDX_W-1:0]           vacant_idx;
   logic [ast_pkg::ADDR_W-1:0] read_data;
   logic [SAT_W-1:0]           count_sat;

   // Index of the lowest set bit of a vector.
   function automatic logic [IDX_W-1:0] lowest_index(input logic [SLOT_COUNT-1:0] vec);
      logic [SLOT_COUNT-1:0] first;
      logic [IDX_W-1:0]      enc;
      first = vec & (~vec + 1'b1);
      enc   = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (first[i]) begin
            enc = enc | IDX_W'(i);
         end
      end
      return enc;
   endfunction

   // Narrow an index to the three bits that the result carries.
   function automatic logic [ast_pkg::HIT_W-1:0] to_hit(input logic [IDX_W-1:0] idx);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(idx);
      return ext[ast_pkg::HIT_W-1:0];
   endfunction

   assign match_idx  = lowest_index(match_ff);
   assign vacant_idx = lowest_index(vacant_ff);

   always_comb begin
      read_data = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (int'(req_ff.slot_select) == i) begin
            read_data = table_ff[i];
         end
      end
   end

   always_comb begin
      wr_en    = 1'b0;
      wr_idx   = '0;
      wr_data  = '0;
      count_in = count_ff;
      rsp_in   = '0;
      unique case (req_ff.func)
         ast_pkg::FUNC_ADD: begin
            if (addr_nz_ff && (|match_ff)) begin
               rsp_in.ok              = 1'b1;
               rsp_in.already_present = 1'b1;
               rsp_in.slot_hit        = to_hit(match_idx);
            end else if (|vacant_ff) begin
               wr_en           = 1'b1;
               wr_idx          = vacant_idx;
               wr_data         = req_ff.address;
               rsp_in.ok       = 1'b1;
               rsp_in.slot_hit = to_hit(vacant_idx);
               if (addr_nz_ff) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         ast_pkg::FUNC_REMOVE: begin
            // A zero address matches the lowest vacant slot and changes nothing.
            if (|match_ff) begin
               wr_en           = 1'b1;
               wr_idx          = match_idx;
               rsp_in.ok       = 1'b1;
               rsp_in.slot_hit = to_hit(match_idx);
               if (addr_nz_ff) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         ast_pkg::FUNC_LOOKUP: begin
            if (addr_nz_ff && (|match_ff)) begin
               rsp_in.ok       = 1'b1;
               rsp_in.slot_hit = to_hit(match_idx);
            end
         end
         ast_pkg::FUNC_READ: begin
            rsp_in.ok        = 1'b1;
            rsp_in.slot_hit  = req_ff.slot_select;
            rsp_in.slot_data = read_data;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
      count_sat = SAT_W'(count_in);
      if (count_sat > SAT_W'(ast_pkg::COUNT_MAX)) begin
         rsp_in.occupied_count = ast_pkg::COUNT_W'(ast_pkg::COUNT_MAX);
      end else begin
         rsp_in.occupied_count = count_sat[ast_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            table_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            count_ff <= count_in;
            if (wr_en) begin
               table_ff[wr_idx] <= wr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.capture_match) begin
         addr_nz_ff <= (req_ff.address != '0);
         for (int i = 0; i < SLOT_COUNT; i++) begin
            match_ff[i]  <= (table_ff[i] == req_ff.address);
            vacant_ff[i] <= (table_ff[i] == '0);
         end
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.out_full = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

// ----- hdl/address_slot_table_unit.sv -----
// ----------------------------------------------------------------------------
// address_slot_table_unit
// Fixed table of 48-bit addresses with add, remove, lookup and slot read.
// ----------------------------------------------------------------------------
// Each operation passes from its request transfer to its result in steps:
// the request is captured, the address is compared against every slot in
// parallel and the match and vacancy vectors are registered, and then the
// table update is committed and the result register loaded. The controller
// handles one operation at a time, so a new request is taken only after the
// last commit; if the previous result has not been transferred, the commit
// waits for it. An all-zero slot is vacant. Add reports a stored address as
// already present, otherwise writes it into the lowest vacant slot; remove
// clears the lowest matching slot and leaves the rest in place; lookup
// never matches a zero address; read returns one slot, or zero beyond the
// table. Every result carries the number of occupied slots, saturated at
// fifteen. Reset clears every slot.
// ----------------------------------------------------------------------------
module address_slot_table_unit #(
   parameter int SLOT_COUNT = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ast_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ast_pkg::rsp_type rsp_data
);

   // Command and status bundles between the controller and the datapath.
   ast_pkg::cmd_type    cmd;
   ast_pkg::status_type status;

   ast_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ast_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/address_slot_table_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_slot_table_unit_tb
// Self-checking bench for the address slot table. A shadow copy of the table
// predicts every result. Requests go in through named test phases: corner
// cases, random traffic with idle gaps on both sides, back-to-back streams, a
// long receiver hold and a full drain pause. Each result transfer is compared
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module address_slot_table_unit_tb;

   localparam int SLOT_COUNT  = 8;
   localparam int POOL_SIZE   = 12;
   localparam int LONG_HOLD   = 80;
   localparam int DRAIN_LIMIT = 2000;
   localparam int PRINT_LIMIT = 50;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ast_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ast_pkg::rsp_type rsp_data;

   // Shadow copy of the slot contents, updated as each request transfer
   // is accepted so that predictions follow the order the block serves them.
   logic [ast_pkg::ADDR_W-1:0] shadow_slots [SLOT_COUNT];
   ast_pkg::rsp_type           pending_rsps [$];
   logic [ast_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];

   // Idle control shared between the test phases and the two channel sides.
   bit tx_idle_on        = 1'b1;
   bit rx_idle_on        = 1'b1;
   bit long_hold_request = 1'b0;

   int mismatch_count = 0;
   int ops_by_func [4] = '{default: 0};
   int adds_refused   = 0;
   int adds_duplicate = 0;
   int longest_hold   = 0;

   address_slot_table_unit #(
      .SLOT_COUNT(SLOT_COUNT)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Lowest slot equal to the value, or -1 when no slot holds it.
   function automatic int first_slot_holding(input logic [ast_pkg::ADDR_W-1:0] value);
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (shadow_slots[i] == value) return i;
      end
      return -1;
   endfunction

   // Applies one operation to the shadow table and returns the result the
   // block should produce for it.
   function automatic ast_pkg::rsp_type predict_table_op(input ast_pkg::req_type op);
      ast_pkg::rsp_type r;
      int               idx;
      int               occupied;
      r   = '0;
      idx = -1;
      case (op.func)
         ast_pkg::FUNC_ADD: begin
            // Zero is never reported as present; it lands in a vacancy instead.
            if (op.address != '0) idx = first_slot_holding(op.address);
            if (idx >= 0) begin
               r.ok              = 1'b1;
               r.already_present = 1'b1;
               r.slot_hit        = idx[ast_pkg::HIT_W-1:0];
            end else begin
               idx = first_slot_holding('0);
               if (idx >= 0) begin
                  shadow_slots[idx] = op.address;
                  r.ok              = 1'b1;
                  r.slot_hit        = idx[ast_pkg::HIT_W-1:0];
               end
            end
         end
         ast_pkg::FUNC_REMOVE: begin
            // Removing zero matches the lowest vacancy, which stays vacant.
            idx = first_slot_holding(op.address);
            if (idx >= 0) begin
               shadow_slots[idx] = '0;
               r.ok              = 1'b1;
               r.slot_hit        = idx[ast_pkg::HIT_W-1:0];
            end
         end
         ast_pkg::FUNC_LOOKUP: begin
            if (op.address != '0) idx = first_slot_holding(op.address);
            if (idx >= 0) begin
               r.ok       = 1'b1;
               r.slot_hit = idx[ast_pkg::HIT_W-1:0];
            end
         end
         default: begin
            r.ok       = 1'b1;
            r.slot_hit = op.slot_select;
            if (int'(op.slot_select) < SLOT_COUNT) r.slot_data = shadow_slots[op.slot_select];
         end
      endcase
      occupied = 0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (shadow_slots[i] != '0) occupied++;
      end
      if (occupied > ast_pkg::COUNT_MAX) occupied = ast_pkg::COUNT_MAX;
      r.occupied_count = occupied[ast_pkg::COUNT_W-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic ast_pkg::req_type make_op(input ast_pkg::func_type f,
                                                input logic [ast_pkg::ADDR_W-1:0] addr,
                                                input logic [ast_pkg::SEL_W-1:0] sel);
      ast_pkg::req_type op;
      op.func        = f;
      op.address     = addr;
      op.slot_select = sel;
      return op;
   endfunction

   function automatic logic [ast_pkg::ADDR_W-1:0] random_address();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[ast_pkg::ADDR_W-1:0];
   endfunction

   // Most addresses come from a small pool, so that adds collide, removes
   // find their target and the table regularly fills up.
   function automatic ast_pkg::req_type random_op(input int add_pct, input int remove_pct);
      ast_pkg::req_type op;
      int               pick;
      int               roll;
      pick = $urandom_range(0, 99);
      if (pick < add_pct) op.func = ast_pkg::FUNC_ADD;
      else if (pick < add_pct + remove_pct) op.func = ast_pkg::FUNC_REMOVE;
      else if (pick < add_pct + remove_pct + (100 - add_pct - remove_pct) * 6 / 10)
         op.func = ast_pkg::FUNC_LOOKUP;
      else op.func = ast_pkg::FUNC_READ;
      roll = $urandom_range(0, 99);
      if (roll < 78) op.address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (roll < 88) op.address = '0;
      else op.address = random_address();
      op.slot_select = ast_pkg::SEL_W'($urandom_range(0, 7));
      return op;
   endfunction

   // Offers one request and returns at the rising edge where it transfers.
   // Valid is left high after the transfer; the next call either keeps it
   // high with new data or lowers it for the idle gap, so it is written only
   // once per falling edge.
   task automatic send_op(input ast_pkg::req_type op);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= op;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_rsps.push_back(predict_table_op(op));
      ops_by_func[op.func]++;
   endtask

   // Stops offering and waits until every predicted result has been taken.
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------

   // Receiver: before each result it holds ready low for a random number of
   // cycles, or for one long stretch when a test phase asks for it.
   initial begin : result_receiver
      int stall;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            stall             = LONG_HOLD;
            long_hold_request = 1'b0;
         end else begin
            stall = rx_idle_on ? $urandom_range(0, 15) : 0;
         end
         if (stall > longest_hold) longest_hold = stall;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Checker: every result transfer is matched against the oldest prediction.
   always @(posedge clock) begin : result_checker
      ast_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsps.size() == 0) begin
            report_mismatch($sformatf("result transfer with nothing outstanding: %h",
                                      rsp_data));
         end else begin
            want = pending_rsps.pop_front();
            if (want.already_present) adds_duplicate++;
            if (rsp_data.ok !== want.ok)
               report_mismatch($sformatf("ok expected %0d got %0d", want.ok, rsp_data.ok));
            if (rsp_data.already_present !== want.already_present)
               report_mismatch($sformatf("already_present expected %0d got %0d",
                                         want.already_present, rsp_data.already_present));
            if (rsp_data.slot_hit !== want.slot_hit)
               report_mismatch($sformatf("slot_hit expected %0d got %0d",
                                         want.slot_hit, rsp_data.slot_hit));
            if (rsp_data.slot_data !== want.slot_data)
               report_mismatch($sformatf("slot_data expected %h got %h",
                                         want.slot_data, rsp_data.slot_data));
            if (rsp_data.occupied_count !== want.occupied_count)
               report_mismatch($sformatf("occupied_count expected %0d got %0d",
                                         want.occupied_count, rsp_data.occupied_count));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test phases
   // ------------------------------------------------------------------------

   // Corner cases starting from the empty table: zero handling on an empty
   // and on a full table, duplicates, filling every slot, refusal when full,
   // reuse of the lowest vacancy after a remove, and reads of every kind.
   task automatic test_directed_corners();
      logic [ast_pkg::ADDR_W-1:0] ones;
      logic [ast_pkg::ADDR_W-1:0] gone;
      ones = '1;
      gone = 48'h5555_5555_5555;
      send_op(make_op(ast_pkg::FUNC_LOOKUP, '0, 3'd0));
      send_op(make_op(ast_pkg::FUNC_REMOVE, '0, 3'd0));
      send_op(make_op(ast_pkg::FUNC_ADD, '0, 3'd0));
      send_op(make_op(ast_pkg::FUNC_ADD, ones, 3'd0));
      send_op(make_op(ast_pkg::FUNC_ADD, ones, 3'd0));
      send_op(make_op(ast_pkg::FUNC_LOOKUP, ones, 3'd0));
      send_op(make_op(ast_pkg::FUNC_ADD, 48'h0000_0000_0001, 3'd0));
      send_op(make_op(ast_pkg::FUNC_ADD, 48'h8000_0000_0000, 3'd0));
      send_op(make_op(ast_pkg::FUNC_ADD, gone, 3'd0));
      send_op(make_op(ast_pkg::FUNC_ADD, 48'hAAAA_AAAA_AAAA, 3'd0));
      for (int i = 0; i < 3; i++)
         send_op(make_op(ast_pkg::FUNC_ADD, random_address() | 48'h1, 3'd0));
      // The table is now full: every add, and zero in any form, is refused.
      send_op(make_op(ast_pkg::FUNC_ADD, 48'h1234_5678_9ABC, 3'd0));
      send_op(make_op(ast_pkg::FUNC_ADD, '0, 3'd0));
      send_op(make_op(ast_pkg::FUNC_REMOVE, '0, 3'd0));
      send_op(make_op(ast_pkg::FUNC_LOOKUP, '0, 3'd0));
      send_op(make_op(ast_pkg::FUNC_READ, ones, 3'd7));
      send_op(make_op(ast_pkg::FUNC_READ, '0, 3'd0));
      send_op(make_op(ast_pkg::FUNC_REMOVE, gone, 3'd0));
      send_op(make_op(ast_pkg::FUNC_LOOKUP, gone, 3'd0));
      send_op(make_op(ast_pkg::FUNC_REMOVE, gone, 3'd0));
      send_op(make_op(ast_pkg::FUNC_ADD, '0, 3'd0));
      send_op(make_op(ast_pkg::FUNC_ADD, 48'h0F0F_0F0F_0F0F, 3'd0));
      send_op(make_op(ast_pkg::FUNC_READ, '0, 3'd3));
      send_op(make_op(ast_pkg::FUNC_READ, ones, 3'd5));
      wait_for_results();
   endtask

   // Random traffic; the pool is partly refreshed now and then so that new
   // addresses keep arriving while old ones linger in the table.
   task automatic test_random_traffic(input int count, input int add_pct,
                                      input int remove_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 39) == 0)
            addr_pool[$urandom_range(0, POOL_SIZE - 1)] = random_address();
         send_op(random_op(add_pct, remove_pct));
      end
   endtask

   // Both sides run without idling, so requests are taken at full rate.
   task automatic test_back_to_back(input int count);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      test_random_traffic(count, 40, 30);
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so the result register fills and the block stops taking requests.
   task automatic test_stall_fill();
      tx_idle_on        = 1'b0;
      long_hold_request = 1'b1;
      test_random_traffic(20, 35, 25);
      tx_idle_on        = 1'b1;
   endtask

   // The sender stops until every outstanding result has arrived.
   task automatic test_drain_pause(input int count);
      test_random_traffic(count, 35, 25);
      wait_for_results();
      test_random_traffic(count, 35, 25);
   endtask

   // ------------------------------------------------------------------------
   // Sequence and end of run
   // ------------------------------------------------------------------------

   initial begin : run_sequence
      int waited;
      for (int i = 0; i < SLOT_COUNT; i++) shadow_slots[i] = '0;
      for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = random_address();
      addr_pool[0] = '1;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_random_traffic(400, 35, 25);
      test_back_to_back(150);
      test_stall_fill();
      test_drain_pause(100);
      test_random_traffic(250, 25, 40);
      test_back_to_back(60);
      test_random_traffic(200, 45, 20);

      // Stop offering, then allow the last results to drain, bounded so that
      // a lost result shows up as an outstanding prediction.
      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (pending_rsps.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (pending_rsps.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_rsps.size()));

      $display("summary: %0d requests (add %0d, remove %0d, lookup %0d, read %0d),",
               ops_by_func[0] + ops_by_func[1] + ops_by_func[2] + ops_by_func[3],
               ops_by_func[ast_pkg::FUNC_ADD], ops_by_func[ast_pkg::FUNC_REMOVE],
               ops_by_func[ast_pkg::FUNC_LOOKUP], ops_by_func[ast_pkg::FUNC_READ]);
      $display("summary: %0d duplicate adds, longest receiver hold %0d cycles, %0d mismatches",
               adds_duplicate, longest_hold, mismatch_count);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run of this sequence.
   initial begin : watchdog
      #5_000_000;
      $display("timeout with %0d results outstanding", pending_rsps.size());
      $display("status: fail");
      $finish;
   end

endmodule
